>>> rtl/htat_pkg.sv
package htat_pkg;

    localparam int LocalEntriesDefault  = 64;
    localparam int RemoteEntriesDefault = 256;

    localparam logic [1:0] ACT_PACKET      = 2'd0;
    localparam logic [1:0] ACT_CLEAR       = 2'd1;
    localparam logic [1:0] ACT_READ_LOCAL  = 2'd2;
    localparam logic [1:0] ACT_READ_REMOTE = 2'd3;

    localparam int InBits  = 2 + 1 + 48 + 32 + 1 + 48 + 32 + 1 + 16 + 8;
    localparam int InBytes = (InBits + 7) / 8;
    localparam int OutBits  = 1 + 8 + 1 + 48 + 32 + 64 + 64 + 1 + 1;
    localparam int OutBytes = (OutBits + 7) / 8;

    // one table row: key address, latest address, counters
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
        logic [63:0] bytes_in;
        logic [63:0] bytes_out;
    } row_t;

    localparam int RowBits = $bits(row_t);

    typedef struct packed {
        logic        from_local_table;
        logic [7:0]  entry_index;
        logic        entry_valid;
        logic [47:0] host_mac;
        logic [31:0] host_ip;
        logic [63:0] total_in;
        logic [63:0] total_out;
        logic        newly_inserted;
        logic        table_full;
    } result_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [15:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {49'd0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

>>> rtl/htat_ram.sv
module htat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/htat_table.sv
// one host table: row memory, fill count and a row-valid flag
module htat_table #(
    parameter int ENTRIES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic [$clog2(ENTRIES)-1:0] raddr,
    output htat_pkg::row_t             rdata,
    output logic                       rvalid_at,
    input  logic                       we,
    input  logic [$clog2(ENTRIES)-1:0] waddr,
    input  htat_pkg::row_t             wdata,
    input  logic                       insert,
    output logic [$clog2(ENTRIES):0]   fill
);
    import htat_pkg::*;
    localparam int AW = $clog2(ENTRIES);

    logic [AW:0]        fill_reg;
    logic [AW-1:0]      raddr_reg;

    htat_ram #(.WIDTH(RowBits), .DEPTH(ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            raddr_reg <= '0;
        end
        else
        begin
            raddr_reg <= raddr;
            if (clear)
            begin
                fill_reg  <= '0;
            end
            else if (insert)
            begin
                fill_reg  <= fill_reg + 1'b1;
            end
        end
    end

    // rows fill from index zero upwards, so a row holds a host below the fill count
    assign rvalid_at = ({1'b0, raddr_reg} < fill_reg);
    assign fill      = fill_reg;
endmodule

>>> rtl/host_traffic_accounting_table.sv
// Per-host byte counters in a local table (keyed by MAC) and a remote table
// (keyed by IPv4). A packet transaction updates the source then the
// destination host and yields two results; a read yields one; a clear and a
// packet without valid addresses yield none. Lookup scans the table one row
// per cycle through a single memory read port, and the block is not ready
// while a packet or read is being processed.
module host_traffic_accounting_table #(
    parameter int LOCAL_ENTRIES  = htat_pkg::LocalEntriesDefault,
    parameter int REMOTE_ENTRIES = htat_pkg::RemoteEntriesDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // action, addresses_valid, src_mac, src_ip, src_is_lan, dst_mac, dst_ip,
    // dst_is_lan, byte_size, read_index
    input  logic [htat_pkg::InBytes*8-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // from_local_table, entry_index, entry_valid, host_mac, host_ip, total_in,
    // total_out, newly_inserted, table_full
    output logic [htat_pkg::OutBytes*8-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);
    import htat_pkg::*;

    localparam int LAW = $clog2(LOCAL_ENTRIES);
    localparam int RAW = $clog2(REMOTE_ENTRIES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_RMW   = 3'd3;
    localparam logic [2:0] ST_RDATA = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_READ  = 3'd6;
    localparam logic [2:0] ST_READW = 3'd7;

    logic [InBits-1:0] in_reg;
    logic [2:0]  state_reg;
    logic        side_reg;      // 0 source, 1 destination
    logic [12:0] idx_reg;       // scan position
    logic        found_reg;
    logic [12:0] hit_reg;
    result_t     res_reg;
    logic        last_reg;

    logic [1:0]  a_action;
    logic        a_valid, s_lan, d_lan;
    logic [47:0] s_mac, d_mac;
    logic [31:0] s_ip, d_ip;
    logic [15:0] a_size;
    logic [7:0]  a_ri;
    assign {a_ri, a_size, d_lan, d_ip, d_mac, s_lan, s_ip, s_mac, a_valid, a_action} = in_reg;

    logic        cur_lan;
    logic [47:0] cur_mac;
    logic [31:0] cur_ip;
    assign cur_lan = side_reg ? d_lan : s_lan;
    assign cur_mac = side_reg ? d_mac : s_mac;
    assign cur_ip  = side_reg ? d_ip : s_ip;

    logic        l_clear, r_clear, l_we, r_we, l_ins, r_ins, l_vat, r_vat;
    logic [LAW-1:0] l_raddr;
    logic [RAW-1:0] r_raddr;
    row_t        l_rdata, r_rdata, wrow;
    logic [LAW:0] l_fill;
    logic [RAW:0] r_fill;

    htat_table #(.ENTRIES(LOCAL_ENTRIES)) u_local (
        .clk(clk), .rst_n(rst_n), .clear(l_clear),
        .raddr(l_raddr), .rdata(l_rdata), .rvalid_at(l_vat),
        .we(l_we), .waddr(hit_reg[LAW-1:0]), .wdata(wrow), .insert(l_ins), .fill(l_fill)
    );
    htat_table #(.ENTRIES(REMOTE_ENTRIES)) u_remote (
        .clk(clk), .rst_n(rst_n), .clear(r_clear),
        .raddr(r_raddr), .rdata(r_rdata), .rvalid_at(r_vat),
        .we(r_we), .waddr(hit_reg[RAW-1:0]), .wdata(wrow), .insert(r_ins), .fill(r_fill)
    );

    // current-side view
    row_t        cur_row;
    logic        cur_vat;
    logic [12:0] cur_fill, cur_n, prev_idx;
    logic        key_match;
    assign cur_row  = cur_lan ? l_rdata : r_rdata;
    assign cur_vat  = cur_lan ? l_vat : r_vat;
    assign cur_fill = cur_lan ? 13'(l_fill) : 13'(r_fill);
    assign cur_n    = cur_lan ? 13'(LOCAL_ENTRIES) : 13'(REMOTE_ENTRIES);
    assign prev_idx = idx_reg - 13'd1;
    assign key_match = cur_vat && (cur_lan ? (cur_row.mac == cur_mac) : (cur_row.ip == cur_ip));

    // read-action view
    logic        rd_local, rd_inrange;
    assign rd_local   = (a_action == ACT_READ_LOCAL);
    assign rd_inrange = rd_local ? ({5'd0, a_ri} < 13'(LOCAL_ENTRIES))
                                 : ({5'd0, a_ri} < 13'(REMOTE_ENTRIES));

    // scan address: idx_reg in SCAN, hit_reg in CHECK and RMW, read index in READ and READW
    always_comb
    begin
        l_raddr = idx_reg[LAW-1:0];
        r_raddr = idx_reg[RAW-1:0];
        if (state_reg == ST_CHECK || state_reg == ST_RMW)
        begin
            l_raddr = hit_reg[LAW-1:0];
            r_raddr = hit_reg[RAW-1:0];
        end
        else if (state_reg == ST_READ || state_reg == ST_READW)
        begin
            l_raddr = LAW'(a_ri);
            r_raddr = RAW'(a_ri);
        end
    end

    // read-modify-write of the row
    logic insert_now;
    assign insert_now = !found_reg;
    always_comb
    begin
        wrow = cur_row;
        if (insert_now)
        begin
            wrow.bytes_in  = '0;
            wrow.bytes_out = '0;
            wrow.mac       = cur_mac;
            wrow.ip        = cur_ip;
        end
        if (cur_lan) wrow.ip = cur_ip;
        else         wrow.mac = cur_mac;
        if (side_reg) wrow.bytes_in  = sat_add(wrow.bytes_in, a_size);
        else          wrow.bytes_out = sat_add(wrow.bytes_out, a_size);
    end

    // full-table and read results
    result_t full_res, read_res;
    always_comb
    begin
        full_res = '0;
        full_res.from_local_table = cur_lan;
        full_res.table_full       = 1'b1;
        read_res = '0;
        read_res.from_local_table = rd_local;
        read_res.entry_index      = a_ri;
        if (rd_inrange && (rd_local ? l_vat : r_vat))
        begin
            read_res.entry_valid = 1'b1;
            read_res.host_mac    = rd_local ? l_rdata.mac : r_rdata.mac;
            read_res.host_ip     = rd_local ? l_rdata.ip : r_rdata.ip;
            read_res.total_in    = rd_local ? l_rdata.bytes_in : r_rdata.bytes_in;
            read_res.total_out   = rd_local ? l_rdata.bytes_out : r_rdata.bytes_out;
        end
    end

    logic do_write;
    assign do_write = (state_reg == ST_RMW);
    assign l_we  = do_write && cur_lan;
    assign r_we  = do_write && !cur_lan;
    assign l_ins = l_we && insert_now;
    assign r_ins = r_we && insert_now;

    logic in_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign l_clear = (state_reg == ST_IDLE) && in_acc && (s_axis_tdata[1:0] == ACT_CLEAR);
    assign r_clear = l_clear;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {(OutBytes*8-OutBits)'(0),
                            res_reg.table_full, res_reg.newly_inserted, res_reg.total_out,
                            res_reg.total_in, res_reg.host_ip, res_reg.host_mac,
                            res_reg.entry_valid, res_reg.entry_index, res_reg.from_local_table};
    assign m_axis_tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            side_reg  <= 1'b0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            hit_reg   <= '0;
            res_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        side_reg  <= 1'b0;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        case (s_axis_tdata[1:0])
                            ACT_PACKET: state_reg <= s_axis_tdata[2] ? ST_SCAN : ST_IDLE;
                            ACT_CLEAR:  state_reg <= ST_IDLE;
                            default:    state_reg <= ST_READ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    // address idx_reg issued now; data of idx_reg-1 visible
                    if (idx_reg != 13'd0 && key_match && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= prev_idx;
                        state_reg <= ST_CHECK;
                    end
                    else if (idx_reg >= cur_fill)
                    begin
                        hit_reg   <= cur_fill;
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 13'd1;
                    end
                end
                ST_CHECK:
                begin
                    if (!found_reg && cur_fill >= cur_n)
                    begin
                        res_reg   <= full_res;
                        last_reg  <= side_reg;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_RMW;
                    end
                end
                ST_RMW:
                begin
                    res_reg.from_local_table <= cur_lan;
                    res_reg.entry_index      <= hit_reg[7:0];
                    res_reg.entry_valid      <= 1'b1;
                    res_reg.host_mac         <= wrow.mac;
                    res_reg.host_ip          <= wrow.ip;
                    res_reg.total_in         <= wrow.bytes_in;
                    res_reg.total_out        <= wrow.bytes_out;
                    res_reg.newly_inserted   <= insert_now;
                    res_reg.table_full       <= 1'b0;
                    last_reg  <= side_reg;
                    state_reg <= ST_OUT;
                end
                ST_READ:
                begin
                    state_reg <= ST_READW;
                end
                ST_READW:
                begin
                    res_reg   <= read_res;
                    last_reg  <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        if (last_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            side_reg  <= 1'b1;
                            idx_reg   <= '0;
                            found_reg <= 1'b0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_reg <= s_axis_tdata[InBits-1:0];
        end
    end

    // a source-side result is never the last of its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !side_reg && !(state_reg == ST_OUT && (a_action == ACT_READ_LOCAL
         || a_action == ACT_READ_REMOTE))) |-> !m_axis_tlast)
        else $error("source result marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_reg.table_full) |-> !res_reg.entry_valid)
        else $error("full table result carries an entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (l_fill <= (LAW+1)'(LOCAL_ENTRIES)) && (r_fill <= (RAW+1)'(REMOTE_ENTRIES)))
        else $error("fill count beyond table size");
endmodule

>>> tb/host_traffic_accounting_table_tb.sv
`timescale 1ns / 1ps

module host_traffic_accounting_table_tb;
    import htat_pkg::*;

    localparam int LocalSize  = LocalEntriesDefault;
    localparam int RemoteSize = RemoteEntriesDefault;

    typedef struct {
        logic [1:0]  action;
        logic        addresses_valid;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic        src_is_lan;
        logic [47:0] dst_mac;
        logic [31:0] dst_ip;
        logic        dst_is_lan;
        logic [15:0] byte_size;
        logic [7:0]  read_index;
    } record_t;

    typedef struct {
        result_t r;
        logic    last;
    } entry_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [InBytes*8-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OutBytes*8-1:0] m_axis_tdata;
    logic m_axis_tlast;

    host_traffic_accounting_table dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    // counter tables
    logic        loc_valid [LocalSize];
    logic [47:0] loc_mac [LocalSize];
    logic [31:0] loc_ip [LocalSize];
    logic [63:0] loc_in [LocalSize];
    logic [63:0] loc_out [LocalSize];
    int          loc_fill;
    logic        rem_valid [RemoteSize];
    logic [31:0] rem_ip [RemoteSize];
    logic [47:0] rem_mac [RemoteSize];
    logic [63:0] rem_in [RemoteSize];
    logic [63:0] rem_out [RemoteSize];
    int          rem_fill;

    record_t       pending_records[$];
    entry_result_t expected_results[$];
    int  failures = 0;
    bit  stimulus_done = 1'b0;
    bit  quiet = 1'b0;
    bit  in_taken = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;

    function automatic logic [63:0] add_saturating(logic [63:0] a, logic [15:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {49'd0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic entry_result_t count_host(logic [47:0] mac, logic [31:0] ip,
                                                 logic lan, logic is_src,
                                                 logic [15:0] size, logic last);
        entry_result_t e;
        int i;
        int hit;
        e.r = '0;
        e.last = last;
        hit = -1;
        e.r.from_local_table = lan;
        if (lan)
        begin
            for (i = 0; i < LocalSize; i++)
                if (hit < 0 && loc_valid[i] && loc_mac[i] == mac) hit = i;
            if (hit < 0)
            begin
                if (loc_fill >= LocalSize)
                begin
                    e.r.table_full = 1'b1;
                    return e;
                end
                hit = loc_fill++;
                loc_valid[hit] = 1'b1;
                loc_mac[hit] = mac;
                loc_in[hit] = '0;
                loc_out[hit] = '0;
                e.r.newly_inserted = 1'b1;
            end
            loc_ip[hit] = ip;
            if (is_src) loc_out[hit] = add_saturating(loc_out[hit], size);
            else loc_in[hit] = add_saturating(loc_in[hit], size);
            e.r.host_mac = loc_mac[hit];
            e.r.host_ip = loc_ip[hit];
            e.r.total_in = loc_in[hit];
            e.r.total_out = loc_out[hit];
        end
        else
        begin
            for (i = 0; i < RemoteSize; i++)
                if (hit < 0 && rem_valid[i] && rem_ip[i] == ip) hit = i;
            if (hit < 0)
            begin
                if (rem_fill >= RemoteSize)
                begin
                    e.r.table_full = 1'b1;
                    return e;
                end
                hit = rem_fill++;
                rem_valid[hit] = 1'b1;
                rem_ip[hit] = ip;
                rem_in[hit] = '0;
                rem_out[hit] = '0;
                e.r.newly_inserted = 1'b1;
            end
            rem_mac[hit] = mac;
            if (is_src) rem_out[hit] = add_saturating(rem_out[hit], size);
            else rem_in[hit] = add_saturating(rem_in[hit], size);
            e.r.host_mac = rem_mac[hit];
            e.r.host_ip = rem_ip[hit];
            e.r.total_in = rem_in[hit];
            e.r.total_out = rem_out[hit];
        end
        e.r.entry_index = hit[7:0];
        e.r.entry_valid = 1'b1;
        return e;
    endfunction

    task automatic account_record(record_t t);
        entry_result_t e;
        int ri;
        ri = t.read_index;
        e.r = '0;
        e.last = 1'b1;
        e.r.entry_index = t.read_index;
        case (t.action)
            ACT_PACKET:
                if (t.addresses_valid)
                begin
                    expected_results.push_back(count_host(t.src_mac, t.src_ip,
                        t.src_is_lan, 1'b1, t.byte_size, 1'b0));
                    expected_results.push_back(count_host(t.dst_mac, t.dst_ip,
                        t.dst_is_lan, 1'b0, t.byte_size, 1'b1));
                end
            ACT_CLEAR:
            begin
                foreach (loc_valid[i]) loc_valid[i] = 1'b0;
                foreach (rem_valid[i]) rem_valid[i] = 1'b0;
                loc_fill = 0;
                rem_fill = 0;
            end
            ACT_READ_LOCAL:
            begin
                e.r.from_local_table = 1'b1;
                if (ri < LocalSize && loc_valid[ri])
                begin
                    e.r.entry_valid = 1'b1;
                    e.r.host_mac = loc_mac[ri];
                    e.r.host_ip = loc_ip[ri];
                    e.r.total_in = loc_in[ri];
                    e.r.total_out = loc_out[ri];
                end
                expected_results.push_back(e);
            end
            default:
            begin
                if (ri < RemoteSize && rem_valid[ri])
                begin
                    e.r.entry_valid = 1'b1;
                    e.r.host_mac = rem_mac[ri];
                    e.r.host_ip = rem_ip[ri];
                    e.r.total_in = rem_in[ri];
                    e.r.total_out = rem_out[ri];
                end
                expected_results.push_back(e);
            end
        endcase
    endtask

    function automatic logic [InBytes*8-1:0] pack_record(record_t t);
        logic [InBytes*8-1:0] d;
        d = '0;
        d[InBits-1:0] = {t.read_index, t.byte_size, t.dst_is_lan, t.dst_ip, t.dst_mac,
                         t.src_is_lan, t.src_ip, t.src_mac, t.addresses_valid, t.action};
        return d;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_records.size() > 0)
                begin
                    s_axis_tdata <= pack_record(pending_records[0]);
                    s_axis_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 9);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 6) == 0) recv_gap <= $urandom_range(1, 9);
            end
        end
    end

    // transaction accept on the input side
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            account_record(pending_records.pop_front());
        end
    end

    // monitor
    always @(posedge clk)
    begin
        entry_result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[9],
                   m_axis_tdata[57:10], m_axis_tdata[89:58], m_axis_tdata[153:90],
                   m_axis_tdata[217:154], m_axis_tdata[218], m_axis_tdata[219]};
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction");
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.from_local_table !== want.r.from_local_table)
                begin
                    $error("from_local_table exp %0h got %0h", want.r.from_local_table,
                           got.from_local_table);
                    failures++;
                end
                if (got.entry_index !== want.r.entry_index)
                begin
                    $error("entry_index exp %0h got %0h", want.r.entry_index, got.entry_index);
                    failures++;
                end
                if (got.entry_valid !== want.r.entry_valid)
                begin
                    $error("entry_valid exp %0h got %0h", want.r.entry_valid, got.entry_valid);
                    failures++;
                end
                if (got.host_mac !== want.r.host_mac)
                begin
                    $error("host_mac exp %0h got %0h", want.r.host_mac, got.host_mac);
                    failures++;
                end
                if (got.host_ip !== want.r.host_ip)
                begin
                    $error("host_ip exp %0h got %0h", want.r.host_ip, got.host_ip);
                    failures++;
                end
                if (got.total_in !== want.r.total_in)
                begin
                    $error("total_in exp %0h got %0h", want.r.total_in, got.total_in);
                    failures++;
                end
                if (got.total_out !== want.r.total_out)
                begin
                    $error("total_out exp %0h got %0h", want.r.total_out, got.total_out);
                    failures++;
                end
                if (got.newly_inserted !== want.r.newly_inserted)
                begin
                    $error("newly_inserted exp %0h got %0h", want.r.newly_inserted,
                           got.newly_inserted);
                    failures++;
                end
                if (got.table_full !== want.r.table_full)
                begin
                    $error("table_full exp %0h got %0h", want.r.table_full, got.table_full);
                    failures++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_result exp %0h got %0h", want.last, m_axis_tlast);
                    failures++;
                end
            end
        end
    end

    // host pools keep hits frequent
    logic [47:0] mac_pool [24];
    logic [31:0] ip_pool [24];

    function automatic record_t random_packet(int pool);
        record_t t;
        int a;
        int b;
        a = $urandom_range(0, pool - 1);
        b = $urandom_range(0, pool - 1);
        t.action = ACT_PACKET;
        t.addresses_valid = ($urandom_range(0, 15) != 0);
        t.src_mac = mac_pool[a];
        t.src_ip = ip_pool[a];
        t.dst_mac = mac_pool[b];
        t.dst_ip = ip_pool[b];
        if ($urandom_range(0, 3) == 0) t.src_ip = $urandom;
        if ($urandom_range(0, 3) == 0) t.dst_mac = 48'({$urandom, $urandom});
        t.src_is_lan = 1'($urandom_range(0, 1));
        t.dst_is_lan = 1'($urandom_range(0, 1));
        t.byte_size = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
        t.read_index = 8'($urandom);
        return t;
    endfunction

    function automatic record_t random_read();
        record_t t;
        t = random_packet(24);
        t.action = $urandom_range(0, 1) ? ACT_READ_LOCAL : ACT_READ_REMOTE;
        t.read_index = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
        return t;
    endfunction

    initial
    begin
        record_t t;
        int n;
        int k;
        foreach (loc_valid[i]) loc_valid[i] = 1'b0;
        foreach (rem_valid[i]) rem_valid[i] = 1'b0;
        loc_fill = 0;
        rem_fill = 0;
        foreach (mac_pool[i])
        begin
            mac_pool[i] = 48'({$urandom, $urandom});
            ip_pool[i] = $urandom;
        end
        mac_pool[0] = '0;
        ip_pool[0] = '0;
        mac_pool[1] = '1;
        ip_pool[1] = '1;

        // directed: extremes, every action, dropped packet, same host, bad reads
        t = random_packet(2);
        t.addresses_valid = 1'b1;
        t.src_mac = '0; t.src_ip = '0; t.src_is_lan = 1'b1;
        t.dst_mac = '1; t.dst_ip = '1; t.dst_is_lan = 1'b0;
        t.byte_size = '1;
        pending_records.push_back(t);
        t.src_is_lan = 1'b0; t.dst_is_lan = 1'b1; t.byte_size = '0;
        pending_records.push_back(t);
        t.dst_mac = '0; t.dst_ip = '0; t.dst_is_lan = 1'b0; t.byte_size = 16'h1234;
        pending_records.push_back(t);
        t.src_is_lan = 1'b1; t.dst_is_lan = 1'b1; t.dst_mac = '0;
        pending_records.push_back(t);
        t.addresses_valid = 1'b0;
        pending_records.push_back(t);
        for (k = 0; k < 3; k++)
        begin
            t.action = ACT_READ_LOCAL; t.read_index = k[7:0];
            pending_records.push_back(t);
            t.action = ACT_READ_REMOTE;
            pending_records.push_back(t);
        end
        t.action = ACT_READ_LOCAL; t.read_index = 8'd255;
        pending_records.push_back(t);
        t.read_index = 8'd64;
        pending_records.push_back(t);
        t.action = ACT_READ_REMOTE; t.read_index = 8'd255;
        pending_records.push_back(t);
        t.action = ACT_CLEAR; t.read_index = '0;
        pending_records.push_back(t);
        t.action = ACT_READ_LOCAL;
        pending_records.push_back(t);
        t.action = ACT_READ_REMOTE;
        pending_records.push_back(t);

        // fill the local table past capacity, then read the top row
        for (k = 0; k < LocalSize + 3; k++)
        begin
            t = random_packet(2);
            t.addresses_valid = 1'b1;
            t.src_is_lan = 1'b1; t.dst_is_lan = 1'b1;
            t.src_mac = 48'h1000 + k; t.dst_mac = 48'h1000 + k;
            pending_records.push_back(t);
        end
        t.action = ACT_READ_LOCAL; t.read_index = 8'd63;
        pending_records.push_back(t);
        t.action = ACT_CLEAR;
        pending_records.push_back(t);

        // random phase
        for (n = 0; n < 200; n++)
        begin
            k = $urandom_range(0, 99);
            if (k < 2)
            begin
                t.action = ACT_CLEAR;
                pending_records.push_back(t);
            end
            else if (k < 25)
            begin
                pending_records.push_back(random_read());
            end
            else
            begin
                pending_records.push_back(random_packet(24));
            end
        end

        // remote table overflow with distinct IPs
        for (k = 0; k < RemoteSize + 4; k++)
        begin
            t = random_packet(2);
            t.addresses_valid = 1'b1;
            t.src_is_lan = 1'b0; t.dst_is_lan = 1'b0;
            t.src_ip = 32'h0a000000 + k; t.dst_ip = 32'h0a000000 + k;
            pending_records.push_back(t);
        end
        t.action = ACT_READ_REMOTE; t.read_index = 8'd255;
        pending_records.push_back(t);
        for (n = 0; n < 60; n++) pending_records.push_back(random_packet(24));

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        wait (pending_records.size() < 80);
        quiet = 1'b1;
        wait (pending_records.size() == 0);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
